/* hdl/fip_pkg.sv */
package fip_pkg;

    localparam int unsigned DW = 64;

    localparam logic [DW-1:0] ONE_BITS  = 64'h3FF0_0000_0000_0000;
    localparam logic [DW-1:0] ZERO_BITS = 64'h0000_0000_0000_0000;
    // default NaN produced by an invalid product (infinity times zero)
    localparam logic [DW-1:0] DNAN_BITS = 64'hFFF8_0000_0000_0000;

    typedef enum logic [2:0] {
        OP_BASE = 3'b001,
        OP_PROD = 3'b010,
        OP_ACC  = 3'b100
    } op_sel_t;

    typedef struct packed {
        logic    load;
        logic    acc_clear;
        logic    acc_write;
        logic    idx_dec;
        logic    mul_start;
        op_sel_t op_sel;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic exp_zero;
        logic base_zero;
        logic cur_bit;
        logic idx_zero;
        logic mul_done;
    } sts_t;

endpackage

/* hdl/fip_fmul.sv */
module fip_fmul (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [fip_pkg::DW-1:0] a_in,
    input  logic [fip_pkg::DW-1:0] b_in,
    output logic                   done,
    output logic [fip_pkg::DW-1:0] res
);
    import fip_pkg::*;

    typedef enum logic [5:0] {
        F_IDLE  = 6'b000001,
        F_PP    = 6'b000010,
        F_ADD   = 6'b000100,
        F_NORM  = 6'b001000,
        F_ROUND = 6'b010000,
        F_HOLD  = 6'b100000
    } fstate_t;

    fstate_t             state_reg, state_next;
    logic [63:0]         a_reg, a_next, b_reg, b_next;
    logic [1:0]          cnt_reg, cnt_next;
    logic [53:0]         pp_reg, pp_next;
    logic [6:0]          sh_reg, sh_next;
    logic [105:0]        p_reg, p_next;
    logic                sticky_reg, sticky_next;
    logic signed [13:0]  e_reg, e_next;
    logic                sgn_reg, sgn_next;
    logic [63:0]         res_reg, res_next;
    logic                done_reg, done_next;

    // operand classification on the incoming words
    logic        ia_nan, ib_nan, ia_inf, ib_inf, ia_zero, ib_zero, isgn;
    logic        spec;
    logic [63:0] spec_res;
    logic [10:0] ea, eb;
    logic [52:0] ma, mb;
    logic [26:0] mx, my;
    logic [105:0] pp_ext;
    logic [13:0]  dsh;
    logic [105:0] dmask;
    logic [52:0]  mrnd;
    logic         g, s, inc;
    logic [53:0]  m54;
    logic [52:0]  mfin;
    logic signed [13:0] efin;

    assign ia_nan  = (a_in[62:52] == 11'h7FF) && (a_in[51:0] != '0);
    assign ib_nan  = (b_in[62:52] == 11'h7FF) && (b_in[51:0] != '0);
    assign ia_inf  = (a_in[62:52] == 11'h7FF) && (a_in[51:0] == '0);
    assign ib_inf  = (b_in[62:52] == 11'h7FF) && (b_in[51:0] == '0);
    assign ia_zero = (a_in[62:0] == '0);
    assign ib_zero = (b_in[62:0] == '0);
    assign isgn    = a_in[63] ^ b_in[63];

    always_comb begin
        spec     = 1'b1;
        spec_res = ZERO_BITS;
        if (ia_nan) begin
            spec_res = a_in | 64'h0008_0000_0000_0000;
        end else if (ib_nan) begin
            spec_res = b_in | 64'h0008_0000_0000_0000;
        end else if ((ia_inf && ib_zero) || (ib_inf && ia_zero)) begin
            spec_res = DNAN_BITS;
        end else if (ia_inf || ib_inf) begin
            spec_res = {isgn, 11'h7FF, 52'd0};
        end else if (ia_zero || ib_zero) begin
            spec_res = {isgn, 63'd0};
        end else begin
            spec = 1'b0;
        end
    end

    assign ea = (a_reg[62:52] == '0) ? 11'd1 : a_reg[62:52];
    assign eb = (b_reg[62:52] == '0) ? 11'd1 : b_reg[62:52];
    assign ma = {(a_reg[62:52] != '0), a_reg[51:0]};
    assign mb = {(b_reg[62:52] != '0), b_reg[51:0]};
    assign mx = cnt_reg[1] ? {1'b0, ma[52:27]} : ma[26:0];
    assign my = cnt_reg[0] ? {1'b0, mb[52:27]} : mb[26:0];
    assign pp_ext = {52'd0, pp_reg} << sh_reg;

    assign dsh   = 14'sd1 - e_reg;
    assign dmask = ~({106{1'b1}} << dsh[6:0]);

    assign mrnd = p_reg[104:52];
    assign g    = p_reg[51];
    assign s    = (p_reg[50:0] != '0) | sticky_reg;
    assign inc  = g & (s | mrnd[0]);
    assign m54  = {1'b0, mrnd} + {53'd0, inc};
    assign mfin = m54[53] ? m54[53:1] : m54[52:0];
    assign efin = m54[53] ? e_reg + 14'sd1 : e_reg;

    always_comb begin
        state_next  = state_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        cnt_next    = cnt_reg;
        pp_next     = pp_reg;
        sh_next     = sh_reg;
        p_next      = p_reg;
        sticky_next = sticky_reg;
        e_next      = e_reg;
        sgn_next    = sgn_reg;
        res_next    = res_reg;
        done_next   = 1'b0;
        case (state_reg)
            F_IDLE: begin
                if (start) begin
                    a_next      = a_in;
                    b_next      = b_in;
                    sgn_next    = isgn;
                    cnt_next    = '0;
                    p_next      = '0;
                    sticky_next = 1'b0;
                    pp_next     = '0;
                    sh_next     = '0;
                    if (spec) begin
                        res_next   = spec_res;
                        state_next = F_HOLD;
                    end else begin
                        state_next = F_PP;
                    end
                end
            end
            F_PP: begin
                // multiply one limb pair, fold in the previous one
                pp_next  = mx * my;
                sh_next  = 7'(({1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]}) * 27);
                p_next   = p_reg + pp_ext;
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd0) begin
                    e_next = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 14'sd1023;
                end
                if (cnt_reg == 2'd3) begin
                    state_next = F_ADD;
                end
            end
            F_ADD: begin
                p_next     = p_reg + pp_ext;
                state_next = F_NORM;
            end
            F_NORM: begin
                if (p_reg[105]) begin
                    sticky_next = sticky_reg | p_reg[0];
                    p_next      = p_reg >> 1;
                    e_next      = e_reg + 14'sd1;
                end else if (!p_reg[104] && (e_reg > 14'sd1)) begin
                    p_next = p_reg << 1;
                    e_next = e_reg - 14'sd1;
                end else if (e_reg < 14'sd1) begin
                    // subnormal result: align to the minimum exponent
                    if (dsh >= 14'sd106) begin
                        sticky_next = sticky_reg | (p_reg != '0);
                        p_next      = '0;
                    end else begin
                        sticky_next = sticky_reg | ((p_reg & dmask) != '0);
                        p_next      = p_reg >> dsh[6:0];
                    end
                    e_next = 14'sd1;
                end else begin
                    state_next = F_ROUND;
                end
            end
            F_ROUND: begin
                if (efin >= 14'sd2047) begin
                    res_next = {sgn_reg, 11'h7FF, 52'd0};
                end else if (mfin[52]) begin
                    res_next = {sgn_reg, efin[10:0], mfin[51:0]};
                end else begin
                    res_next = {sgn_reg, 11'd0, mfin[51:0]};
                end
                state_next = F_HOLD;
            end
            F_HOLD: begin
                done_next  = 1'b1;
                state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        a_reg      <= a_next;
        b_reg      <= b_next;
        cnt_reg    <= cnt_next;
        pp_reg     <= pp_next;
        sh_reg     <= sh_next;
        p_reg      <= p_next;
        sticky_reg <= sticky_next;
        e_reg      <= e_next;
        sgn_reg    <= sgn_next;
        res_reg    <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

/* hdl/fip_dp.sv */
module fip_dp #(
    parameter int EXP_BITS = 31,
    parameter int S_W      = 96
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  fip_pkg::cmd_t          cmd,
    output fip_pkg::sts_t          sts,
    input  logic [S_W-1:0]         s_tdata,
    output logic [fip_pkg::DW-1:0] m_tdata
);
    import fip_pkg::*;

    localparam int IDX_W = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;

    logic [DW-1:0]       base_reg, base_next;
    logic [EXP_BITS-1:0] exp_reg, exp_next;
    logic [DW-1:0]       acc_reg, acc_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [DW-1:0]       out_reg, out_next;
    logic [DW-1:0]       op_a, prod;
    logic                mul_done;

    always_comb begin
        case (cmd.op_sel)
            OP_BASE: op_a = base_reg;
            OP_PROD: op_a = prod;
            OP_ACC:  op_a = acc_reg;
            default: op_a = acc_reg;
        endcase
    end

    fip_fmul u_fmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .a_in    (op_a),
        .b_in    (acc_reg),
        .done    (mul_done),
        .res     (prod)
    );

    always_comb begin
        base_next = base_reg;
        exp_next  = exp_reg;
        acc_next  = acc_reg;
        idx_next  = idx_reg;
        out_next  = out_reg;
        if (cmd.load) begin
            base_next = s_tdata[DW-1:0];
            exp_next  = s_tdata[DW +: EXP_BITS];
            acc_next  = ONE_BITS;
            idx_next  = IDX_W'(EXP_BITS - 1);
        end
        if (cmd.acc_clear) begin
            acc_next = ZERO_BITS;
        end
        if (cmd.acc_write) begin
            acc_next = prod;
        end
        if (cmd.idx_dec) begin
            idx_next = idx_reg - 1'b1;
        end
        if (cmd.out_load) begin
            out_next = acc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        base_reg <= base_next;
        exp_reg  <= exp_next;
        acc_reg  <= acc_next;
        idx_reg  <= idx_next;
        out_reg  <= out_next;
    end

    assign sts.exp_zero  = (exp_reg == '0);
    assign sts.base_zero = (base_reg[DW-2:0] == '0);
    assign sts.cur_bit   = exp_reg[idx_reg];
    assign sts.idx_zero  = (idx_reg == '0);
    assign sts.mul_done  = mul_done;
    assign m_tdata       = out_reg;

endmodule

/* hdl/fip_ctrl.sv */
module fip_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  fip_pkg::sts_t sts,
    output fip_pkg::cmd_t cmd
);
    import fip_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHECK = 6'b000010,
        S_SCAN  = 6'b000100,
        S_BA    = 6'b001000,
        S_SQ    = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   seen_reg, seen_next;
    logic   mval_reg, mval_next;

    always_comb begin
        state_next = state_reg;
        seen_next  = seen_reg;
        mval_next  = mval_reg;
        cmd        = '0;
        cmd.op_sel = OP_ACC;
        if (mval_reg && m_tready) begin
            mval_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    seen_next  = 1'b0;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (sts.exp_zero) begin
                    state_next = S_DONE;
                end else if (sts.base_zero) begin
                    cmd.acc_clear = 1'b1;
                    state_next    = S_DONE;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (sts.cur_bit) begin
                    seen_next     = 1'b1;
                    cmd.mul_start = 1'b1;
                    cmd.op_sel    = OP_BASE;
                    state_next    = S_BA;
                end else if (seen_reg) begin
                    cmd.mul_start = 1'b1;
                    cmd.op_sel    = OP_ACC;
                    state_next    = S_SQ;
                end else begin
                    // leading zeros leave the accumulator at one: skip
                    cmd.idx_dec = 1'b1;
                end
            end
            S_BA: begin
                if (sts.mul_done) begin
                    cmd.mul_start = 1'b1;
                    cmd.op_sel    = OP_PROD;
                    state_next    = S_SQ;
                end
            end
            S_SQ: begin
                if (sts.mul_done) begin
                    cmd.acc_write = 1'b1;
                    if (sts.idx_zero) begin
                        state_next = S_DONE;
                    end else begin
                        cmd.idx_dec = 1'b1;
                        state_next  = S_SCAN;
                    end
                end
            end
            S_DONE: begin
                if (!mval_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    mval_next    = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            seen_reg  <= 1'b0;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            seen_reg  <= seen_next;
            mval_reg  <= mval_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mval_reg;

endmodule

/* hdl/float_integer_power.sv */
// float_integer_power: raises a double precision base to a non-negative
// integer power by square-and-multiply, scanning the exponent from its top.
// Input channel s_: one word carries the base bits and the exponent.
// Output channel m_: one word per input word, the result as a double.
// One item is in flight at a time; s_tready is high only while idle.
// Leading zero exponent bits are skipped without a multiply. From the
// highest set bit down, each bit costs one squaring, plus a base product
// where the bit is set; both run on one shared double multiplier that
// forms the 53x53 mantissa product from four 27x27 partial products.
// Its normaliser works step by step, so a multiply takes longer when the
// product needs a right shift or an operand is subnormal.
// A zero exponent or zero base skips the multiplies and goes straight
// to the output register.
// The result sits in an output register; while the receiver stalls the
// next item may be accepted and computed, and waits only to be handed over.
// Reset (aresetn low, synchronous) drops any item in flight and clears
// m_tvalid.
module float_integer_power #(
    parameter int EXP_BITS = 31
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // base_bits [63:0], exponent [64 +: EXP_BITS], zero padding above
    input  logic [((64+EXP_BITS+7)/8)*8-1:0] s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // result_bits [63:0]
    output logic [63:0]                       m_tdata
);
    import fip_pkg::*;

    localparam int S_W = ((64 + EXP_BITS + 7) / 8) * 8;

    cmd_t cmd;
    sts_t sts;

    fip_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fip_dp #(
        .EXP_BITS (EXP_BITS),
        .S_W      (S_W)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata)
    );

endmodule

/* hdl/fip_checker.sv */
module fip_checker #(
    parameter int EXP_BITS = 31
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    // a held result word must not change
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // one item at a time: accept closes the input side
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word taken while busy");

    // a result never appears in the cycle right after an accept
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared too early");

endmodule

bind float_integer_power fip_checker #(.EXP_BITS(EXP_BITS)) u_fip_checker (.*);
